>>> design/rrt_pkg.sv
package rrt_pkg;

  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 2048;

  localparam int unsigned SumW  = 30;
  localparam int unsigned CntW  = 23;
  localparam int unsigned ProdW = 31;
  localparam int unsigned MsW   = 16;
  localparam int unsigned QuoW  = 8;
  localparam int unsigned AddrW = 5;

  localparam logic [1:0] OpPixel = 2'd0;
  localparam logic [1:0] OpEof   = 2'd1;
  localparam logic [1:0] OpTick  = 2'd2;

  localparam logic [2:0] RegRoiLeft   = 3'd0;
  localparam logic [2:0] RegRoiTop    = 3'd1;
  localparam logic [2:0] RegRoiRight  = 3'd2;
  localparam logic [2:0] RegRoiBottom = 3'd3;
  localparam logic [2:0] RegRedLevel  = 3'd4;
  localparam logic [2:0] RegRedLead   = 3'd5;
  localparam logic [2:0] RegCooldown  = 3'd6;

  typedef struct packed {
    logic [10:0]    roi_left;
    logic [10:0]    roi_top;
    logic [11:0]    roi_right;
    logic [11:0]    roi_bottom;
    logic [7:0]     red_level;
    logic [7:0]     red_lead;
    logic [MsW-1:0] hold_off_ms;
  } rrt_cfg_t;

  typedef struct packed {
    logic pix;
    logic tick;
    logic mul_en;
    logic cmp_en;
    logic div_en;
    logic fin;
  } rrt_cmd_t;

  typedef struct packed {
    logic div_last;
  } rrt_sts_t;

endpackage

>>> design/rrt_if.sv
interface rrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [10:0] col;
  logic [10:0] row;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;

  modport source (output valid, operation, col, row, blue, green, red, input ready);
  modport sink (input valid, operation, col, row, blue, green, red, output ready);
endinterface

interface rrt_out_if;
  logic       valid;
  logic       ready;
  logic       red_detected;
  logic       trigger_accepted;
  logic [7:0] red_avg;

  modport source (output valid, red_detected, trigger_accepted, red_avg, input ready);
  modport sink (input valid, red_detected, trigger_accepted, red_avg, output ready);
endinterface

>>> design/rrt_regs.sv
module rrt_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [rrt_pkg::AddrW-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output rrt_pkg::rrt_cfg_t       cfg_o
);
  import rrt_pkg::*;

  rrt_cfg_t   cfg_q;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[AddrW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr) begin
      unique case (idx)
        RegRoiLeft:   cfg_q.roi_left    <= pwdata[10:0];
        RegRoiTop:    cfg_q.roi_top     <= pwdata[10:0];
        RegRoiRight:  cfg_q.roi_right   <= pwdata[11:0];
        RegRoiBottom: cfg_q.roi_bottom  <= pwdata[11:0];
        RegRedLevel:  cfg_q.red_level   <= pwdata[7:0];
        RegRedLead:   cfg_q.red_lead    <= pwdata[7:0];
        RegCooldown:  cfg_q.hold_off_ms <= pwdata[MsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegRoiLeft:   prdata = {21'b0, cfg_q.roi_left};
      RegRoiTop:    prdata = {21'b0, cfg_q.roi_top};
      RegRoiRight:  prdata = {20'b0, cfg_q.roi_right};
      RegRoiBottom: prdata = {20'b0, cfg_q.roi_bottom};
      RegRedLevel:  prdata = {24'b0, cfg_q.red_level};
      RegRedLead:   prdata = {24'b0, cfg_q.red_lead};
      RegCooldown:  prdata = {16'b0, cfg_q.hold_off_ms};
      default:      prdata = '0;
    endcase
  end

endmodule

>>> design/rrt_ctrl.sv
module rrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_op_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rrt_pkg::rrt_sts_t sts_i,
  output rrt_pkg::rrt_cmd_t cmd_o
);
  import rrt_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StCmp  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc, out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          cmd_o.pix  = (in_op_i == OpPixel);
          cmd_o.tick = (in_op_i == OpTick);
          if (in_op_i == OpEof) state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul_en = 1'b1;
        state_d      = StCmp;
      end
      StCmp: begin
        cmd_o.cmp_en = 1'b1;
        state_d      = StDiv;
      end
      StDiv: begin
        cmd_o.div_en = 1'b1;
        if (sts_i.div_last) state_d = StDone;
      end
      StDone: begin
        if (out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.fin) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_eof_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_op_i == OpEof |=> state_q == StMul)
    else $error("end of frame did not start the decision");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StDone)
    else $error("result raised outside done state");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv && !sts_i.div_last |=> state_q == StDiv)
    else $error("division left early");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |-> !out_valid_q || out_ready_i)
    else $error("pending result overwritten");

endmodule

>>> design/rrt_dp.sv
module rrt_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrt_pkg::rrt_cfg_t cfg_i,
  input  rrt_pkg::rrt_cmd_t cmd_i,
  output rrt_pkg::rrt_sts_t sts_o,
  input  logic [10:0]       col_i,
  input  logic [10:0]       row_i,
  input  logic [7:0]        blue_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        red_i,
  output logic              red_detected_o,
  output logic              trigger_accepted_o,
  output logic [7:0]        red_avg_o
);
  import rrt_pkg::*;

  logic [SumW-1:0]  sum_b_q, sum_g_q, sum_r_q;
  logic [CntW-1:0]  cnt_q;
  logic [MsW-1:0]   ms_q;
  logic [ProdW-1:0] prod_level_q, prod_lead_q;
  logic             ok_q;
  logic [SumW-1:0]  rem_q, dvs_q;
  logic [QuoW-1:0]  quo_q;
  logic [2:0]       step_q;
  logic             det_q, acc_q;
  logic [7:0]       mean_q;

  logic            in_roi, cnt_zero, det, acc, rem_ge;
  logic [SumW:0]   add_b, add_g, add_r;
  logic [SumW+1:0] lhs_r, rhs_lvl, rhs_g, rhs_b;

  assign in_roi = ({1'b0, col_i} >= {1'b0, cfg_i.roi_left}) && ({1'b0, col_i} < cfg_i.roi_right)
               && ({1'b0, row_i} >= {1'b0, cfg_i.roi_top}) && ({1'b0, row_i} < cfg_i.roi_bottom)
               && ({21'b0, col_i} < 32'(MaxWidth)) && ({21'b0, row_i} < 32'(MaxHeight));

  assign add_b = {1'b0, sum_b_q} + {{(SumW-7){1'b0}}, blue_i};
  assign add_g = {1'b0, sum_g_q} + {{(SumW-7){1'b0}}, green_i};
  assign add_r = {1'b0, sum_r_q} + {{(SumW-7){1'b0}}, red_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_b_q <= '0;
      sum_g_q <= '0;
      sum_r_q <= '0;
      cnt_q   <= '0;
    end else if (cmd_i.fin) begin
      sum_b_q <= '0;
      sum_g_q <= '0;
      sum_r_q <= '0;
      cnt_q   <= '0;
    end else if (cmd_i.pix && in_roi) begin
      sum_b_q <= add_b[SumW] ? '1 : add_b[SumW-1:0];
      sum_g_q <= add_g[SumW] ? '1 : add_g[SumW-1:0];
      sum_r_q <= add_r[SumW] ? '1 : add_r[SumW-1:0];
      if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
    end
  end

  assign cnt_zero = (cnt_q == '0);
  assign det      = !cnt_zero && ok_q;
  assign acc      = det && (ms_q >= cfg_i.hold_off_ms);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q <= '1;
    end else if (cmd_i.fin && acc) begin
      ms_q <= '0;
    end else if (cmd_i.tick && ms_q != '1) begin
      ms_q <= ms_q + 1'b1;
    end
  end

  assign lhs_r   = {2'b0, sum_r_q};
  assign rhs_lvl = {1'b0, prod_level_q};
  assign rhs_g   = {2'b0, sum_g_q} + {1'b0, prod_lead_q};
  assign rhs_b   = {2'b0, sum_b_q} + {1'b0, prod_lead_q};
  assign rem_ge  = (rem_q >= dvs_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_level_q <= ProdW'(cfg_i.red_level) * ProdW'(cnt_q);
      prod_lead_q  <= ProdW'(cfg_i.red_lead) * ProdW'(cnt_q);
    end
    if (cmd_i.cmp_en) begin
      ok_q  <= (lhs_r > rhs_lvl) && (lhs_r > rhs_g) && (lhs_r > rhs_b);
      rem_q <= sum_r_q;
      dvs_q <= {cnt_q, {(SumW-CntW){1'b0}}};
    end else if (cmd_i.div_en) begin
      if (rem_ge) rem_q <= rem_q - dvs_q;
      dvs_q <= dvs_q >> 1;
      quo_q <= {quo_q[QuoW-2:0], rem_ge};
    end
    if (cmd_i.fin) begin
      det_q  <= det;
      acc_q  <= acc;
      mean_q <= cnt_zero ? '0 : quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.cmp_en) begin
      step_q <= 3'(QuoW - 1);
    end else if (cmd_i.div_en) begin
      step_q <= step_q - 1'b1;
    end
  end

  assign sts_o.div_last    = (step_q == '0);
  assign red_detected_o     = det_q;
  assign trigger_accepted_o = acc_q;
  assign red_avg_o          = mean_q;

endmodule

>>> design/roi_red_trigger_with_cooldown_core.sv
// Red region trigger: sums B/G/R of warped-frame pixels inside the configured rectangle and, at
// end of frame, emits one result beat with the raw red decision, the cooldown-gated trigger and
// the truncated red mean; sums clear after each frame. Pixel and tick beats are taken one per
// cycle while the block is idle. An end-of-frame beat holds the input off until it is through:
// after its accept come multiply, compare, 8 steps of the restoring divider that forms the mean
// one quotient bit per cycle, and the result load, which also waits while an earlier result
// beat is still untaken.
module roi_red_trigger_with_cooldown_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rrt_in_if.sink                    in_i,
  rrt_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rrt_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import rrt_pkg::*;

  rrt_cfg_t cfg;
  rrt_cmd_t cmd;
  rrt_sts_t sts;

  rrt_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  rrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrt_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .col_i             (in_i.col),
    .row_i             (in_i.row),
    .blue_i            (in_i.blue),
    .green_i           (in_i.green),
    .red_i             (in_i.red),
    .red_detected_o    (out_o.red_detected),
    .trigger_accepted_o(out_o.trigger_accepted),
    .red_avg_o         (out_o.red_avg)
  );

endmodule

>>> tb/sv/roi_red_trigger_with_cooldown_core_tb.sv
`timescale 1ns / 100ps

module roi_red_trigger_with_cooldown_core_tb;
  import rrt_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned StallCycles = 300;
  localparam longint unsigned SumSat = (64'd1 << SumW) - 1;
  localparam int unsigned CntSat = (32'd1 << CntW) - 1;

  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] col;
    logic [10:0] row;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } beat_t;

  typedef struct packed {
    logic       detected;
    logic       accepted;
    logic [7:0] mean;
  } verdict_t;

  typedef struct packed {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] value;
    beat_t       beat;
    bit          typed;
    verdict_t    want;
  } tbl_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rrt_in_if  pix_if ();
  rrt_out_if verdict_if ();

  roi_red_trigger_with_cooldown_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (pix_if),
    .out_o   (verdict_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  rrt_cfg_t        roi_cfg;
  longint unsigned acc_blue, acc_green, acc_red;
  int unsigned     acc_cnt;
  logic [MsW-1:0]  ms_count;

  verdict_t    verdict_q[$];
  tbl_row_t    dir_tbl[$];
  int          err_cnt;
  int unsigned beats_sent;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  bit          stall_req;
  int unsigned quiet_cycles;

  // Advances the region sums, the cooldown counter and, at end of frame, forms the verdict.
  task automatic track_red_roi(input beat_t bt, output bit has_verdict, output verdict_t v);
    bit in_roi;
    longint unsigned n;
    bit ok;
    has_verdict = 1'b0;
    v = '0;
    case (bt.op)
      OpPixel: begin
        in_roi = bt.col >= roi_cfg.roi_left && bt.col < roi_cfg.roi_right &&
                 bt.row >= roi_cfg.roi_top && bt.row < roi_cfg.roi_bottom &&
                 bt.col < MaxWidth && bt.row < MaxHeight;
        if (in_roi) begin
          acc_blue = (acc_blue + bt.blue > SumSat) ? SumSat : acc_blue + bt.blue;
          acc_green = (acc_green + bt.green > SumSat) ? SumSat : acc_green + bt.green;
          acc_red = (acc_red + bt.red > SumSat) ? SumSat : acc_red + bt.red;
          acc_cnt = (acc_cnt + 1 > CntSat) ? CntSat : acc_cnt + 1;
        end
      end
      OpTick: begin
        if (ms_count != '1) ms_count = ms_count + 1'b1;
      end
      OpEof: begin
        has_verdict = 1'b1;
        if (acc_cnt != 0) begin
          n = acc_cnt;
          ok = acc_red > roi_cfg.red_level * n &&
               acc_red > acc_green + roi_cfg.red_lead * n &&
               acc_red > acc_blue + roi_cfg.red_lead * n;
          v.mean = 8'((acc_red / n) & 64'hFF);
          if (ok) begin
            v.detected = 1'b1;
            if (ms_count >= roi_cfg.hold_off_ms) begin
              v.accepted = 1'b1;
              ms_count = '0;
            end
          end
        end
        acc_blue = 0;
        acc_green = 0;
        acc_red = 0;
        acc_cnt = 0;
      end
      default: ;
    endcase
  endtask

  task automatic push_beat(input beat_t bt, input bit typed, input verdict_t want);
    bit has_verdict;
    verdict_t v;
    @(negedge clk_i);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid     <= 1'b1;
    pix_if.operation <= bt.op;
    pix_if.col       <= bt.col;
    pix_if.row       <= bt.row;
    pix_if.blue      <= bt.blue;
    pix_if.green     <= bt.green;
    pix_if.red       <= bt.red;
    do @(posedge clk_i); while (!pix_if.ready);
    track_red_roi(bt, has_verdict, v);
    if (has_verdict) verdict_q.push_back(typed ? want : v);
    if (bt.op != OpUnused) beats_sent++;
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegRoiLeft:   roi_cfg.roi_left = val[10:0];
      RegRoiTop:    roi_cfg.roi_top = val[10:0];
      RegRoiRight:  roi_cfg.roi_right = val[11:0];
      RegRoiBottom: roi_cfg.roi_bottom = val[11:0];
      RegRedLevel:  roi_cfg.red_level = val[7:0];
      RegRedLead:   roi_cfg.red_lead = val[7:0];
      RegCooldown:  roi_cfg.hold_off_ms = val[MsW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic beat_t rand_beat(input logic [1:0] op);
    beat_t bt;
    bt.op    = op;
    bt.col   = 11'($urandom_range(2047, 0));
    bt.row   = 11'($urandom_range(2047, 0));
    bt.blue  = 8'($urandom_range(255, 0));
    bt.green = 8'($urandom_range(255, 0));
    bt.red   = 8'($urandom_range(255, 0));
    return bt;
  endfunction

  function automatic tbl_row_t mk_beat(input logic [1:0] op, input int c, input int r,
                                       input int b, input int g, input int rd);
    tbl_row_t t;
    t = '0;
    t.beat = '{op: op, col: 11'(c), row: 11'(r), blue: 8'(b), green: 8'(g), red: 8'(rd)};
    return t;
  endfunction

  function automatic tbl_row_t mk_cfg(input logic [2:0] idx, input int val);
    tbl_row_t t;
    t = '0;
    t.is_cfg  = 1'b1;
    t.reg_idx = idx;
    t.value   = 32'(val);
    return t;
  endfunction

  function automatic tbl_row_t mk_eof(input bit det, input bit acc, input int mean);
    tbl_row_t t;
    t = mk_beat(OpEof, 0, 0, 0, 0, 0);
    t.typed = 1'b1;
    t.want  = '{detected: det, accepted: acc, mean: 8'(mean)};
    return t;
  endfunction

  function automatic int unsigned pick_edge(input int unsigned lo_val, input int unsigned hi_val);
    case ($urandom_range(9, 0))
      0: return lo_val;
      1: return hi_val;
      default: return $urandom_range(hi_val, lo_val);
    endcase
  endfunction

  // Random small region, at times empty, inverted or on the edge; random red and cooldown.
  task automatic shuffle_cfg();
    int unsigned left, top, right, bottom;
    settle();
    left = pick_edge(0, 2047);
    top = pick_edge(0, 2047);
    right = left + $urandom_range(8, 1);
    bottom = top + $urandom_range(8, 1);
    if (right > 2048 || $urandom_range(9, 0) == 0) right = 2048;
    if (bottom > 2048 || $urandom_range(9, 0) == 0) bottom = 2048;
    if ($urandom_range(11, 0) == 0) right = $urandom_range(left, 0);
    if ($urandom_range(11, 0) == 0) bottom = $urandom_range(top, 0);
    apb_write(RegRoiLeft, left);
    apb_write(RegRoiTop, top);
    apb_write(RegRoiRight, right);
    apb_write(RegRoiBottom, bottom);
    apb_write(RegRedLevel, pick_edge(0, 255) % 181 == 0 ? pick_edge(0, 255)
                                                          : $urandom_range(180, 0));
    apb_write(RegRedLead, ($urandom_range(7, 0) == 0) ? 255 : pick_edge(0, 60));
    case ($urandom_range(7, 0))
      0: apb_write(RegCooldown, 0);
      1: apb_write(RegCooldown, 65535);
      default: apb_write(RegCooldown, $urandom_range(15, 0));
    endcase
  endtask

  task automatic send_frame(input bit tiny);
    int unsigned npix, c_lo, c_hi, r_lo, r_hi;
    bit reddish;
    beat_t bt;
    npix = tiny ? 3 : $urandom_range(30, 4);
    reddish = 1'($urandom_range(1, 0));
    c_lo = (roi_cfg.roi_left == 0) ? 0 : roi_cfg.roi_left - 1;
    r_lo = (roi_cfg.roi_top == 0) ? 0 : roi_cfg.roi_top - 1;
    c_hi = (roi_cfg.roi_right > 2047) ? 2047 : roi_cfg.roi_right;
    r_hi = (roi_cfg.roi_bottom > 2047) ? 2047 : roi_cfg.roi_bottom;
    if (c_hi < c_lo) c_hi = (c_lo + 3 > 2047) ? 2047 : c_lo + 3;
    if (r_hi < r_lo) r_hi = (r_lo + 3 > 2047) ? 2047 : r_lo + 3;
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(99, 0) < 15) push_beat(rand_beat(OpTick), 1'b0, '0);
      if ($urandom_range(99, 0) < 2) push_beat(rand_beat(OpUnused), 1'b0, '0);
      bt = rand_beat(OpPixel);
      if ($urandom_range(99, 0) < 80) begin
        bt.col = 11'($urandom_range(c_hi, c_lo));
        bt.row = 11'($urandom_range(r_hi, r_lo));
      end
      if (reddish) begin
        bt.red   = 8'($urandom_range(255, 150));
        bt.green = 8'($urandom_range(120, 0));
        bt.blue  = 8'($urandom_range(120, 0));
      end
      push_beat(bt, 1'b0, '0);
    end
    push_beat(rand_beat(OpEof), 1'b0, '0);
  endtask

  // Result side: random backpressure plus one long hold-off on request.
  initial begin
    verdict_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        repeat (StallCycles) begin
          verdict_if.ready <= 1'b0;
          @(negedge clk_i);
        end
      end
      verdict_if.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_verdict
    verdict_t want;
    if (rst_ni && verdict_if.valid && verdict_if.ready) begin
      if (verdict_q.size() == 0) begin
        $error("result beat with no verdict pending");
        err_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (verdict_if.red_detected !== want.detected) begin
          $error("red_detected mismatch: expected %0d, got %0d", want.detected,
                 verdict_if.red_detected);
          err_cnt++;
        end
        if (verdict_if.trigger_accepted !== want.accepted) begin
          $error("trigger_accepted mismatch: expected %0d, got %0d", want.accepted,
                 verdict_if.trigger_accepted);
          err_cnt++;
        end
        if (verdict_if.red_avg !== want.mean) begin
          $error("red_avg mismatch: expected %0d, got %0d", want.mean, verdict_if.red_avg);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_if.valid && pix_if.ready) || (verdict_if.valid && verdict_if.ready) ||
          (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    bit stalled;
    int unsigned goal;
    rst_ni = 1'b0;
    pix_if.valid = 1'b0;
    pix_if.operation = OpPixel;
    pix_if.col = '0;
    pix_if.row = '0;
    pix_if.blue = '0;
    pix_if.green = '0;
    pix_if.red = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    roi_cfg = '0;
    acc_blue = 0;
    acc_green = 0;
    acc_red = 0;
    acc_cnt = 0;
    ms_count = '1;
    err_cnt = 0;
    beats_sent = 0;
    src_idle_pct = 7;
    sink_idle_pct = 78;
    stall_req = 1'b0;
    quiet_cycles = 0;
    stalled = 1'b0;

    dir_tbl = '{
      mk_eof(0, 0, 0),
      mk_beat(OpPixel, 0, 0, 255, 255, 255),
      mk_beat(OpUnused, 2047, 2047, 255, 255, 255),
      mk_beat(OpTick, 0, 0, 0, 0, 0),
      mk_eof(0, 0, 0),
      mk_cfg(RegRoiRight, 2048),
      mk_cfg(RegRoiBottom, 2048),
      mk_beat(OpPixel, 2047, 2047, 0, 0, 255),
      mk_eof(1, 1, 255),
      mk_beat(OpPixel, 0, 0, 0, 0, 0),
      mk_eof(0, 0, 0),
      mk_cfg(RegCooldown, 65535),
      mk_cfg(RegRedLevel, 255),
      mk_beat(OpPixel, 1, 1, 0, 0, 255),
      mk_eof(0, 0, 255),
      mk_cfg(RegRedLevel, 0),
      mk_cfg(RegRedLead, 255),
      mk_beat(OpPixel, 2, 2, 0, 0, 255),
      mk_eof(0, 0, 255),
      mk_cfg(RegRedLead, 0),
      mk_beat(OpPixel, 3, 3, 10, 10, 11),
      mk_eof(1, 0, 11),
      mk_cfg(RegCooldown, 2),
      mk_beat(OpTick, 0, 0, 0, 0, 0),
      mk_beat(OpTick, 0, 0, 0, 0, 0),
      mk_beat(OpPixel, 4, 4, 0, 0, 200),
      mk_eof(1, 1, 200),
      mk_cfg(RegRoiLeft, 10),
      mk_cfg(RegRoiTop, 2047),
      mk_beat(OpPixel, 9, 2047, 0, 0, 255),
      mk_beat(OpPixel, 10, 2047, 1, 2, 9),
      mk_beat(OpPixel, 2047, 2047, 3, 4, 10),
      mk_beat(OpPixel, 10, 2046, 0, 0, 255),
      mk_beat(OpEof, 0, 0, 0, 0, 0),
      mk_cfg(RegRoiRight, 10),
      mk_beat(OpPixel, 10, 2047, 0, 0, 255),
      mk_eof(0, 0, 0)
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) begin
        settle();
        apb_write(dir_tbl[i].reg_idx, dir_tbl[i].value);
      end else begin
        push_beat(dir_tbl[i].beat, dir_tbl[i].typed, dir_tbl[i].want);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin src_idle_pct = 7;  sink_idle_pct = 78; end
        1: begin src_idle_pct = 78; sink_idle_pct = 7;  end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      goal = 26 + (mode + 1) * 542;
      while (beats_sent < goal) begin
        shuffle_cfg();
        if (mode == 2 && !stalled) begin
          stalled = 1'b1;
          stall_req = 1'b1;
          repeat (8) send_frame(1'b1);
        end else begin
          repeat (4) send_frame(1'b0);
        end
      end
    end

    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
